// File: sv/button_debounce_hold_repeat_core_macros.svh
// Assertion macros for the button debounce hold repeat core.
// Included by bdhr_engine, which checks its own state; no other dependencies.
`ifndef BUTTON_DEBOUNCE_HOLD_REPEAT_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_REPEAT_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BDHR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdhr check failed");
`define BDHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdhr check failed");
`else
`define BDHR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BDHR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/bdhr_pkg.sv
// Shared types and constants for the button debounce hold repeat core.
// No dependencies.
`default_nettype none
package bdhr_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] RegDebounce      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHold          = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRepeat        = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPressOnPress  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegReleaseAlways = 3'd4;
  localparam logic [CfgIdxW-1:0] RegActiveLow     = 3'd5;

  localparam logic [7:0]  DebounceReset = 8'd50;
  localparam logic [14:0] HoldReset     = 15'd500;
  localparam logic [14:0] RepeatReset   = 15'd100;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_HOLD    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_RELEASE = 3'd4
  } event_e;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [14:0] hold_ms;
    logic [14:0] repeat_ms;
    logic        press_on_press;
    logic        release_always;
    logic        active_low;
  } cfg_t;

  typedef struct packed {
    event_e code;
    logic   pressed;
    logic   holding;
  } result_t;

endpackage
`default_nettype wire

// File: sv/button_debounce_hold_repeat_core.sv
// A poll word lands in the input register when accepted; its result word is valid from
// the result register once it advances. One poll word per cycle while the output is not stalled.
// The per-poll decision is combinational: three parallel time subtracts with compares.
// Reset (async, active low) clears both pipeline valids and the debounce/hold state,
// and loads the configuration registers with their default values.
// Depends on bdhr_pkg, bdhr_cfg and bdhr_engine.
`default_nettype none
module button_debounce_hold_repeat_core #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          pin_level_i,
  input  wire logic [31:0]                   now_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         event_code_o,
  output logic                               pressed_now_o,
  output logic                               holding_now_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bdhr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bdhr_pkg::CfgDataW-1:0] cfg_wdata_i
);

  bdhr_pkg::cfg_t    cfg;
  bdhr_pkg::result_t res, res_q;

  logic        in_valid_q, out_valid_q;
  logic        pin_q;
  logic [31:0] now_q;
  logic        adv, fire;

  assign adv         = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && adv;
  assign in_stall_o  = in_valid_q && !adv;
  assign cfg_ready_o = 1'b1;

  bdhr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdhr_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .pin_level_i (pin_q),
    .now_i       (TIME_BITS'(now_q)),
    .cfg_i       (cfg),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      pin_q <= pin_level_i;
      now_q <= now_ms_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_code_o  = res_q.code;
  assign pressed_now_o = res_q.pressed;
  assign holding_now_o = res_q.holding;

endmodule
`default_nettype wire

// File: sv/bdhr_cfg.sv
// Configuration register file for the button debounce hold repeat core.
// Depends on bdhr_pkg.
`default_nettype none
module bdhr_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [bdhr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bdhr_pkg::CfgDataW-1:0] cfg_wdata_i,
  output bdhr_pkg::cfg_t                     cfg_o
);

  bdhr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms    <= bdhr_pkg::DebounceReset;
      cfg_q.hold_ms        <= bdhr_pkg::HoldReset;
      cfg_q.repeat_ms      <= bdhr_pkg::RepeatReset;
      cfg_q.press_on_press <= 1'b0;
      cfg_q.release_always <= 1'b0;
      cfg_q.active_low     <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bdhr_pkg::RegDebounce:      cfg_q.debounce_ms    <= cfg_wdata_i[7:0];
        bdhr_pkg::RegHold:          cfg_q.hold_ms        <= cfg_wdata_i[14:0];
        bdhr_pkg::RegRepeat:        cfg_q.repeat_ms      <= cfg_wdata_i[14:0];
        bdhr_pkg::RegPressOnPress:  cfg_q.press_on_press <= cfg_wdata_i[0];
        bdhr_pkg::RegReleaseAlways: cfg_q.release_always <= cfg_wdata_i[0];
        bdhr_pkg::RegActiveLow:     cfg_q.active_low     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: sv/bdhr_engine.sv
// Debounce, hold and repeat state with the per-poll event decision.
// Depends on bdhr_pkg and button_debounce_hold_repeat_core_macros.svh.
`default_nettype none
`include "button_debounce_hold_repeat_core_macros.svh"
module bdhr_engine #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire logic                 pin_level_i,
  input  wire logic [TIME_BITS-1:0] now_i,
  input  wire bdhr_pkg::cfg_t       cfg_i,
  output bdhr_pkg::result_t         result_o
);

  logic                 stable_q, armed_q, holding_q, rep_q;
  logic [TIME_BITS-1:0] last_q, hst_q, rst_q;

  logic                 level, chg, acc, press_acc, rel_acc;
  logic [TIME_BITS-1:0] el_db, el_hold, el_rep;
  logic                 armed1, holding1, rep1;
  logic                 hs, rp;
  logic                 armed2, holding2, rep2;
  bdhr_pkg::event_e     edge_ev, ev;

  assign level     = pin_level_i ^ cfg_i.active_low;
  assign el_db     = now_i - last_q;
  assign el_hold   = now_i - hst_q;
  assign el_rep    = now_i - rst_q;
  assign chg       = level != stable_q;
  assign acc       = chg && (el_db > TIME_BITS'(cfg_i.debounce_ms));
  assign press_acc = acc && level;
  assign rel_acc   = acc && !level;

  always_comb begin
    edge_ev = bdhr_pkg::EV_NONE;
    if (press_acc && cfg_i.press_on_press) begin
      edge_ev = bdhr_pkg::EV_PRESS;
    end else if (rel_acc) begin
      if (holding_q || cfg_i.release_always) begin
        edge_ev = bdhr_pkg::EV_RELEASE;
      end else if (!cfg_i.press_on_press) begin
        edge_ev = bdhr_pkg::EV_PRESS;
      end
    end
  end

  assign armed1   = press_acc | (armed_q & ~rel_acc);
  assign holding1 = holding_q & ~rel_acc;
  assign rep1     = rep_q & ~rel_acc;

  assign hs = level && armed1 &&
              (press_acc ? (cfg_i.hold_ms == '0) : (el_hold >= TIME_BITS'(cfg_i.hold_ms)));
  assign armed2   = armed1 & ~hs;
  assign holding2 = holding1 | hs;
  assign rep2     = rep1 | hs;
  assign rp = level && rep2 &&
              (hs ? (cfg_i.repeat_ms == '0) : (el_rep >= TIME_BITS'(cfg_i.repeat_ms)));

  always_comb begin
    priority if (rp) begin
      ev = bdhr_pkg::EV_REPEAT;
    end else if (hs) begin
      ev = bdhr_pkg::EV_HOLD;
    end else begin
      ev = edge_ev;
    end
  end

  assign result_o = '{code: ev, pressed: armed2 | holding2, holding: holding2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= 1'b0;
      armed_q   <= 1'b0;
      holding_q <= 1'b0;
      rep_q     <= 1'b0;
      last_q    <= '0;
      hst_q     <= '0;
      rst_q     <= '0;
    end else if (fire_i) begin
      armed_q   <= armed2;
      holding_q <= holding2;
      rep_q     <= rep2;
      if (acc) begin
        stable_q <= level;
      end
      if (chg) begin
        last_q <= now_i;
      end
      if (press_acc) begin
        hst_q <= now_i;
      end
      if (hs || rp) begin
        rst_q <= now_i;
      end
    end
  end

  `BDHR_ASSERT_IMPLIES(a_armed_xor_hold, clk_i, rst_ni, armed_q, !holding_q)
  `BDHR_ASSERT_IMPLIES(a_repeat_tracks_hold, clk_i, rst_ni, 1'b1, rep_q == holding_q)
  `BDHR_ASSERT_IMPLIES(a_pressed_is_stable, clk_i, rst_ni, armed_q || holding_q, stable_q)
  `BDHR_ASSERT_NEXT(a_hold_sets_holding, clk_i, rst_ni, fire_i && ev == bdhr_pkg::EV_HOLD, holding_q)

endmodule
`default_nettype wire
